### rtl/first_fit_block_allocator_assert.svh
// Assertion macros for the first-fit block allocator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// property must hold at every clock edge outside reset
`define FFBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define FFBA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffba_pkg;
	localparam int WORDS = 256;
	localparam int AW = $clog2(WORDS);
	localparam int DW = 9;
	localparam int SW = DW + 1;
	localparam int CW = AW + 1;
	localparam int NSLOT = 6;
	localparam int XW = $clog2(NSLOT);
	localparam logic [DW-1:0] NIL = '1;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE,
		ST_A_CHK, ST_A_LEN, ST_A_NEXT, ST_A_FIT,
		ST_F_CHK, ST_F_NEXT, ST_F_PREV, ST_F_PLEN, ST_F_LEN,
		ST_F_NLEN, ST_F_AFT, ST_F_PLAN,
		ST_WRITE, ST_RESP
	} state_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
		logic [DW-1:0] data;
	} wslot_t;

	function automatic logic in_store(logic [DW-1:0] v);
		return {1'b0, v} < SW'(WORDS);
	endfunction

	function automatic logic last_word(logic [DW-1:0] v);
		return ({1'b0, v} + SW'(1)) >= SW'(WORDS);
	endfunction

	function automatic logic [SW-1:0] add_w(logic [DW-1:0] a, logic [DW-1:0] b);
		return {1'b0, a} + {1'b0, b};
	endfunction
endpackage

### rtl/ffba_ram.sv
// Generic simple dual-port synchronous RAM, registered read.
// No dependencies.
module ffba_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/ffba_ctrl.sv
// Sequencer: walks the free list in the word RAM and plans the write-back.
// Depends on ffba_pkg.
module ffba_ctrl
	import ffba_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic            cmd,
	input  logic [7:0]      request_size,
	input  logic [7:0]      block_offset,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output logic [7:0]      granted_offset,
	output logic            status,
	output mem_req_t        mem_req,
	input  logic [DW-1:0]   mem_rdata
);
	state_t state_q, state_d;
	logic [DW-1:0] need_q, need_d, loc_q, loc_d, cur_q, cur_d, prev_q, prev_d;
	logic [DW-1:0] len_q, len_d, plen_q, plen_d, nlen_q, nlen_d, after_q, after_d;
	logic [DW-1:0] head_q, head_d;
	logic [CW-1:0] steps_q, steps_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [XW-1:0] widx_q, widx_d;
	logic          mn_q, mn_d;
	logic [7:0]    gnt_q, gnt_d;
	logic          stat_q, stat_d;
	wslot_t        slot_q [NSLOT];
	wslot_t        slot_d [NSLOT];

	logic [DW-1:0] nxt, rem, repl;
	logic [SW-1:0] split;
	logic          fit_split, mp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			widx_q  <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			head_q  <= head_d;
			widx_q  <= widx_d;
		end
	end

	always_ff @(posedge clk) begin
		need_q  <= need_d;
		loc_q   <= loc_d;
		cur_q   <= cur_d;
		prev_q  <= prev_d;
		len_q   <= len_d;
		plen_q  <= plen_d;
		nlen_q  <= nlen_d;
		after_q <= after_d;
		steps_q <= steps_d;
		mn_q    <= mn_d;
		gnt_q   <= gnt_d;
		stat_q  <= stat_d;
		slot_q  <= slot_d;
	end

	always_comb begin
		state_d = state_q;
		need_d  = need_q;
		loc_d   = loc_q;
		cur_d   = cur_q;
		prev_d  = prev_q;
		len_d   = len_q;
		plen_d  = plen_q;
		nlen_d  = nlen_q;
		after_d = after_q;
		head_d  = head_q;
		steps_d = steps_q;
		clr_d   = clr_q;
		widx_d  = widx_q;
		mn_d    = mn_q;
		gnt_d   = gnt_q;
		stat_d  = stat_q;
		slot_d  = slot_q;
		mem_req = '0;
		nxt       = last_word(cur_q) ? NIL : mem_rdata;
		rem       = len_q - need_q;
		split     = add_w(cur_q, need_q);
		fit_split = (rem >= DW'(2)) && ((split + SW'(1)) < SW'(WORDS));
		repl      = fit_split ? split[DW-1:0] : nxt;
		mp        = in_store(prev_q) && (add_w(prev_q, plen_q) == {1'b0, loc_q});

		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				if (clr_q == AW'(0)) begin
					mem_req.wdata = DW'(WORDS);
				end else if (clr_q == AW'(1)) begin
					mem_req.wdata = NIL;
				end else begin
					mem_req.wdata = '0;
				end
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					need_d  = {1'b0, request_size} + DW'(1);
					loc_d   = {1'b0, block_offset};
					cur_d   = head_q;
					prev_d  = NIL;
					plen_d  = '0;
					steps_d = '0;
					widx_d  = '0;
					gnt_d   = '0;
					stat_d  = 1'b0;
					for (int i = 0; i < NSLOT; i++) begin
						slot_d[i] = '0;
					end
					if (cmd == CMD_ALLOC) begin
						state_d = ST_A_CHK;
					end else if (last_word({1'b0, block_offset})) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_F_CHK;
					end
				end
			end
			ST_A_CHK: begin
				mem_req.raddr = cur_q[AW-1:0];
				if (steps_q == CW'(WORDS) || !in_store(cur_q)) begin
					stat_d  = 1'b1;
					state_d = ST_RESP;
				end else begin
					state_d = ST_A_LEN;
				end
			end
			ST_A_LEN: begin
				len_d         = mem_rdata;
				mem_req.raddr = cur_q[AW-1:0] + AW'(1);
				state_d       = (mem_rdata >= need_q) ? ST_A_FIT : ST_A_NEXT;
			end
			ST_A_NEXT: begin
				prev_d  = cur_q;
				cur_d   = nxt;
				steps_d = steps_q + CW'(1);
				state_d = ST_A_CHK;
			end
			ST_A_FIT: begin
				slot_d[0] = '{fit_split, split[AW-1:0], rem};
				slot_d[1] = '{fit_split, split[AW-1:0] + AW'(1), nxt};
				slot_d[2] = '{fit_split, cur_q[AW-1:0], need_q};
				slot_d[3] = '{!last_word(cur_q), cur_q[AW-1:0] + AW'(1), '0};
				if (!in_store(prev_q)) begin
					head_d = repl;
				end else begin
					slot_d[4] = '{!last_word(prev_q), prev_q[AW-1:0] + AW'(1), repl};
				end
				gnt_d   = cur_q[7:0];
				state_d = ST_WRITE;
			end
			ST_F_CHK: begin
				mem_req.raddr = cur_q[AW-1:0] + AW'(1);
				if (steps_q == CW'(WORDS)) begin
					cur_d   = NIL;
					state_d = ST_F_PREV;
				end else if (in_store(cur_q) && cur_q < loc_q) begin
					state_d = ST_F_NEXT;
				end else begin
					state_d = ST_F_PREV;
				end
			end
			ST_F_NEXT: begin
				prev_d  = cur_q;
				cur_d   = nxt;
				steps_d = steps_q + CW'(1);
				state_d = ST_F_CHK;
			end
			ST_F_PREV: begin
				if (cur_q == loc_q) begin
					state_d = ST_RESP;
				end else if (in_store(prev_q)) begin
					mem_req.raddr = prev_q[AW-1:0];
					state_d       = ST_F_PLEN;
				end else begin
					mem_req.raddr = loc_q[AW-1:0];
					state_d       = ST_F_LEN;
				end
			end
			ST_F_PLEN: begin
				plen_d        = mem_rdata;
				mem_req.raddr = loc_q[AW-1:0];
				if (add_w(prev_q, mem_rdata) > {1'b0, loc_q}) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_F_LEN;
				end
			end
			ST_F_LEN: begin
				len_d         = mem_rdata;
				mn_d          = in_store(cur_q) && (add_w(loc_q, mem_rdata) == {1'b0, cur_q});
				mem_req.raddr = cur_q[AW-1:0];
				state_d       = mn_d ? ST_F_NLEN : ST_F_PLAN;
			end
			ST_F_NLEN: begin
				nlen_d        = mem_rdata;
				mem_req.raddr = cur_q[AW-1:0] + AW'(1);
				state_d       = ST_F_AFT;
			end
			ST_F_AFT: begin
				after_d = nxt;
				state_d = ST_F_PLAN;
			end
			ST_F_PLAN: begin
				if (mn_q && mp) begin
					slot_d[0] = '{1'b1, prev_q[AW-1:0], plen_q + len_q + nlen_q};
					slot_d[1] = '{!last_word(prev_q), prev_q[AW-1:0] + AW'(1), after_q};
					slot_d[2] = '{1'b1, loc_q[AW-1:0], '0};
					slot_d[3] = '{1'b1, loc_q[AW-1:0] + AW'(1), '0};
					slot_d[4] = '{1'b1, cur_q[AW-1:0], '0};
					slot_d[5] = '{!last_word(cur_q), cur_q[AW-1:0] + AW'(1), '0};
				end else if (mn_q) begin
					slot_d[0] = '{1'b1, loc_q[AW-1:0], len_q + nlen_q};
					slot_d[1] = '{1'b1, loc_q[AW-1:0] + AW'(1), after_q};
					slot_d[2] = '{1'b1, cur_q[AW-1:0], '0};
					slot_d[3] = '{!last_word(cur_q), cur_q[AW-1:0] + AW'(1), '0};
					if (!in_store(prev_q)) begin
						head_d = loc_q;
					end else begin
						slot_d[4] = '{!last_word(prev_q), prev_q[AW-1:0] + AW'(1), loc_q};
					end
				end else if (mp) begin
					slot_d[0] = '{1'b1, prev_q[AW-1:0], plen_q + len_q};
					slot_d[1] = '{1'b1, loc_q[AW-1:0], '0};
					slot_d[2] = '{1'b1, loc_q[AW-1:0] + AW'(1), '0};
				end else begin
					slot_d[0] = '{1'b1, loc_q[AW-1:0] + AW'(1), in_store(cur_q) ? cur_q : NIL};
					if (!in_store(prev_q)) begin
						head_d = loc_q;
					end else begin
						slot_d[1] = '{!last_word(prev_q), prev_q[AW-1:0] + AW'(1), loc_q};
					end
				end
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				mem_req.we    = slot_q[widx_q].en;
				mem_req.waddr = slot_q[widx_q].addr;
				mem_req.wdata = slot_q[widx_q].data;
				widx_d        = widx_q + XW'(1);
				if (widx_q == XW'(NSLOT - 1)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_ready      = (state_q == ST_IDLE);
	assign rsp_valid      = (state_q == ST_RESP);
	assign granted_offset = gnt_q;
	assign status         = stat_q;
endmodule

### rtl/first_fit_block_allocator.sv
// First-fit block allocator over a 256-word store held in one RAM. After reset
// a clearing pass over all 256 words initializes the store; no transaction is
// taken meanwhile. One transaction is handled at a time: an allocate walks the
// free list until a block fits; a free walks to its place in the list and reads
// the lengths of the neighbours that it may merge with. The walk is bound by the
// single RAM read port and its registered read.
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator
	import ffba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic       cmd,
	input  logic [7:0] request_size,
	input  logic [7:0] block_offset,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] granted_offset,
	output logic       status
);
	mem_req_t      mem_req;
	logic [DW-1:0] mem_rdata;

	ffba_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.cmd            (cmd),
		.request_size   (request_size),
		.block_offset   (block_offset),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.granted_offset (granted_offset),
		.status         (status),
		.mem_req        (mem_req),
		.mem_rdata      (mem_rdata)
	);

	ffba_ram #(
		.DEPTH (WORDS),
		.WIDTH (DW)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	`FFBA_NEVER(a_one_at_a_time, rsp_valid && req_ready, "request taken while response pending")
	`FFBA_ASSERT(a_busy_after_req, (req_valid && req_ready) |=> !req_ready, "ready stayed high after transaction")
	`FFBA_ASSERT(a_fail_zero, (rsp_valid && status) |-> (granted_offset == 8'd0), "failed allocate with nonzero offset")
	`FFBA_NEVER(a_write_while_idle, req_ready && mem_req.we, "RAM write while idle")
endmodule

### verif/first_fit_block_allocator_tb.sv
// Self-checking testbench for first_fit_block_allocator: a directed table and then random
// allocate/free traffic, checked against an in-bench model of the address-ordered free list.
// Depends on ffba_pkg and the RTL of the allocator.
`timescale 1ns / 100ps

module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	localparam int NWORDS = 256;
	localparam int LIST_END = 511;
	localparam logic STAT_OK = 1'b0;
	localparam logic STAT_NOFIT = 1'b1;
	localparam int RANDOM_ITEMS = 1230;

	typedef struct {
		logic [7:0] offset;
		logic       st;
	} grant_t;

	typedef struct {
		cmd_t       op;
		logic [7:0] size;
		logic [7:0] offset;
		bit         known;
		logic [7:0] exp_offset;
		logic       exp_st;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	logic       cmd = CMD_ALLOC;
	logic [7:0] request_size = '0;
	logic [7:0] block_offset = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	logic [7:0] granted_offset;
	logic       status;

	int     heap[NWORDS];
	int     head;
	grant_t grant_q[$];
	int     live_q[$];
	int     errors = 0;
	int     n_alloc = 0, n_free = 0, n_nofit = 0, n_checked = 0;
	bit     calm = 1'b0;

	first_fit_block_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.cmd(cmd), .request_size(request_size), .block_offset(block_offset),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.granted_offset(granted_offset), .status(status)
	);

	always #2 clk = ~clk;

	function automatic int next_of(int b);
		return (b + 1 >= NWORDS) ? LIST_END : heap[b + 1];
	endfunction

	function automatic void relink(int prev, int target);
		if (prev >= NWORDS)
			head = target & 'h1FF;
		else if (prev + 1 < NWORDS)
			heap[prev + 1] = target & 'h1FF;
	endfunction

	function automatic void clear_link(int at);
		if (at < NWORDS)
			heap[at] = 0;
	endfunction

	function automatic grant_t first_fit_grant(int size);
		grant_t g;
		int need, prev, cur, len, nxt, repl, split;
		need = size + 1;
		prev = LIST_END;
		cur = head;
		g.offset = '0;
		g.st = STAT_NOFIT;
		for (int steps = 0; steps < NWORDS && cur < NWORDS; steps++) begin
			len = heap[cur];
			if (len >= need) begin
				nxt = next_of(cur);
				repl = nxt;
				split = cur + need;
				if (len - need >= 2 && split + 1 < NWORDS) begin
					heap[split] = (len - need) & 'h1FF;
					heap[split + 1] = nxt & 'h1FF;
					heap[cur] = need & 'h1FF;
					repl = split;
				end
				clear_link(cur + 1);
				relink(prev, repl);
				g.offset = cur[7:0];
				g.st = STAT_OK;
				return g;
			end
			prev = cur;
			cur = next_of(cur);
		end
		return g;
	endfunction

	function automatic void release_block(int loc);
		int prev, nxt, steps, len, after;
		bit join_next, join_prev;
		if (loc + 1 >= NWORDS)
			return;
		prev = LIST_END;
		nxt = head;
		for (steps = 0; steps < NWORDS && nxt < NWORDS && nxt < loc; steps++) begin
			prev = nxt;
			nxt = next_of(nxt);
		end
		if (steps >= NWORDS)
			nxt = LIST_END;
		if (nxt == loc)
			return;
		if (prev < NWORDS && prev + heap[prev] > loc)
			return;
		len = heap[loc];
		join_next = nxt < NWORDS && loc + len == nxt;
		join_prev = prev < NWORDS && prev + heap[prev] == loc;
		if (join_next && join_prev) begin
			after = next_of(nxt);
			heap[prev] = (heap[prev] + len + heap[nxt]) & 'h1FF;
			heap[prev + 1] = after & 'h1FF;
			heap[loc] = 0;
			heap[loc + 1] = 0;
			heap[nxt] = 0;
			clear_link(nxt + 1);
		end else if (join_next) begin
			after = next_of(nxt);
			heap[loc] = (len + heap[nxt]) & 'h1FF;
			heap[loc + 1] = after & 'h1FF;
			heap[nxt] = 0;
			clear_link(nxt + 1);
			relink(prev, loc);
		end else if (join_prev) begin
			heap[prev] = (heap[prev] + len) & 'h1FF;
			heap[loc] = 0;
			heap[loc + 1] = 0;
		end else begin
			heap[loc + 1] = (nxt < NWORDS) ? nxt : LIST_END;
			relink(prev, loc);
		end
	endfunction

	// apply one accepted transaction to the model, queue what the block must answer
	function automatic void account(cmd_t op, int size, int loc, bit known, grant_t typed);
		grant_t g;
		if (op == CMD_ALLOC) begin
			g = first_fit_grant(size);
			n_alloc++;
			if (g.st == STAT_NOFIT)
				n_nofit++;
			else
				live_q.push_back(g.offset);
		end else begin
			release_block(loc);
			n_free++;
			foreach (live_q[i])
				if (live_q[i] == loc) begin
					live_q.delete(i);
					break;
				end
			g.offset = '0;
			g.st = STAT_OK;
		end
		if (known)
			g = typed;
		grant_q.push_back(g);
	endfunction

	task automatic issue(cmd_t op, int size, int loc, bit known = 0, grant_t typed = '{0, 0});
		req_valid <= 1'b1;
		cmd <= op;
		request_size <= size[7:0];
		block_offset <= loc[7:0];
		do @(posedge clk); while (!req_ready);
		account(op, size, loc, known, typed);
		if (!calm && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (grant_q.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (grant_q.size() == 0) begin
				$error("response with no transaction outstanding");
				errors++;
			end else begin
				grant_t g;
				g = grant_q.pop_front();
				n_checked++;
				if (granted_offset !== g.offset) begin
					$error("granted_offset expected %0d actual %0d", g.offset, granted_offset);
					errors++;
				end
				if (status !== g.st) begin
					$error("status expected %0d actual %0d", g.st, status);
					errors++;
				end
			end
		end
		rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
	end

	row_t plan[] = '{
		'{CMD_ALLOC, 8'd255, 8'd0,   1, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd1,   8'd0,   1, 8'd0, STAT_NOFIT},
		'{CMD_FREE,  8'd0,   8'd0,   1, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd255, 1, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd0,   1, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd0,   8'd0,   1, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd254, 8'd0,   0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd0,   0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd1,   0, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd3,   8'd0,   0, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd3,   8'd0,   0, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd3,   8'd0,   0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd0,   0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd8,   0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd8,   0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd4,   0, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd250, 8'd0,   0, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd2,   8'd0,   0, 8'd0, STAT_OK},
		'{CMD_ALLOC, 8'd170, 8'd0,   0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd254, 0, 8'd0, STAT_OK},
		'{CMD_FREE,  8'd0,   8'd170, 0, 8'd0, STAT_OK}
	};

	initial begin
		int r, loc;
		grant_t typed;
		for (int i = 0; i < NWORDS; i++)
			heap[i] = 0;
		heap[0] = NWORDS & 'h1FF;
		heap[1] = LIST_END;
		head = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			typed.offset = plan[i].exp_offset;
			typed.st = plan[i].exp_st;
			issue(plan[i].op, plan[i].size, plan[i].offset, plan[i].known, typed);
		end
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 400 && n < 600);
			r = $urandom_range(99);
			if (live_q.size() != 0 && r < 45) begin
				loc = live_q[$urandom_range(live_q.size() - 1)];
				issue(CMD_FREE, $urandom_range(255), loc);
			end else if (r < 52) begin
				issue(CMD_FREE, $urandom_range(255), $urandom_range(255));
			end else if ($urandom_range(99) < 85) begin
				issue(CMD_ALLOC, $urandom_range(1, 24), $urandom_range(255));
			end else begin
				issue(CMD_ALLOC, $urandom_range(255), $urandom_range(255));
			end
			if (n == 700)
				drain();
		end
		calm = 1'b0;
		drain();
		repeat (100) @(posedge clk);

		$display("Covered %0d allocates (%0d without a fit) and %0d frees; %0d responses checked.",
			n_alloc, n_nofit, n_free, n_checked);
		if (errors == 0 && grant_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
